### hw/rtl/isv_pkg.sv
// Shared types and constants of the inertial spin Verlet step.
// Beat layouts, configuration register indexes and datapath widths.
// No dependencies.
package isv_pkg;

    typedef struct packed {
        logic        operation;
        logic [31:0] dir_x;
        logic [31:0] dir_y;
        logic [31:0] dir_z;
        logic [31:0] modulus;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] force_x;
        logic [31:0] force_y;
        logic [31:0] force_z;
        logic [31:0] spin_inertia;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] new_dir_x;
        logic [31:0] new_dir_y;
        logic [31:0] new_dir_z;
        logic [31:0] new_modulus;
        logic [31:0] new_vel_x;
        logic [31:0] new_vel_y;
        logic [31:0] new_vel_z;
    } t_out_beat;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPIN_ENABLE = 2'd0,
        CFG_TIME_STEP   = 2'd1,
        CFG_KICK_SCALE  = 2'd2
    } t_cfg_idx;

    localparam logic OP_KICK_DRIFT = 1'b0;

    localparam int KICK_Q_W = 33;
    localparam int DIR_Q_W  = 31;
    localparam int ROOT_W   = 50;

endpackage

### hw/rtl/isv_stream_if.sv
// Valid/ready stream interface carrying one beat of type T.
// Used by the inertial spin Verlet step ports; depends on nothing.
interface isv_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/isv_delay.sv
// Enabled shift line that carries sideband data beside a pipelined unit.
// Generic; depends on nothing.
module isv_delay #(
    parameter type T     = logic,
    parameter int  DEPTH = 1
) (
    input  logic i_clk,
    input  logic i_en,
    input  T     i_d,
    output T     o_q
);
    T r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_q[i] <= r_q[i-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];
endmodule

### hw/rtl/isv_udiv.sv
// Pipelined restoring divider, one quotient bit per stage.
// Expects the remainder part of i_acc below i_den; depends on nothing.
module isv_udiv #(
    parameter int DEN_W = 64,
    parameter int Q_W   = 33
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DEN_W+Q_W-1:0] i_acc,
    input  logic [DEN_W-1:0]     i_den,
    output logic [Q_W-1:0]       o_quo
);
    localparam int W = DEN_W + Q_W;

    logic [W-1:0]     r_acc [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        logic [W-1:0]     acc_in;
        logic [DEN_W-1:0] den_in;
        logic [W:0]       t;
        logic [DEN_W:0]   top;
        logic [W-1:0]     n_acc;

        if (j == 0) begin : g_first
            assign acc_in = i_acc;
            assign den_in = i_den;
        end else begin : g_next
            assign acc_in = r_acc[j-1];
            assign den_in = r_den[j-1];
        end

        always_comb begin
            t   = {acc_in, 1'b0};
            top = t[W:Q_W];
            if (top >= {1'b0, den_in}) begin
                top  = top - {1'b0, den_in};
                t[0] = 1'b1;
            end
            n_acc = {top[DEN_W-1:0], t[Q_W-1:0]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[j] <= n_acc;
                r_den[j] <= den_in;
            end
        end
    end

    assign o_quo = r_acc[Q_W-1][Q_W-1:0];
endmodule

### hw/rtl/isv_usqrt.sv
// Pipelined digit-by-digit floor square root, one root bit per stage.
// Depends on nothing.
module isv_usqrt #(
    parameter int ROOT_W = 50
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W-1:0]     o_root
);
    localparam int IN_W = 2 * ROOT_W;

    logic [IN_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic [IN_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [IN_W:0]     trial;
        logic [IN_W-1:0]   n_rem;
        logic [ROOT_W-1:0] n_root;

        if (j == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        always_comb begin
            trial        = (IN_W+1)'(root_in) << (B + 1);
            trial[2*B]   = 1'b1;
            n_rem        = rem_in;
            n_root       = root_in;
            if ({1'b0, rem_in} >= trial) begin
                n_rem     = rem_in - trial[IN_W-1:0];
                n_root[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
endmodule

### hw/rtl/inertial_spin_verlet_step.sv
// One spin record enters per cycle and a full pipeline sustains one beat per clock, both
// while the output is not stalled. The pipeline holds the 33-stage kick divider, the
// 50-stage square root of the drifted length and the 31-stage direction divider, plus 11
// stages of multiply, add and select. A stall at the output freezes every stage at once.
module inertial_spin_verlet_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    isv_stream_if.sink                    i_in,
    isv_stream_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  logic [isv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data
);
    import isv_pkg::*;

    localparam int NSTG = 3 + KICK_Q_W + 6 + ROOT_W + 1 + DIR_Q_W + 1;
    localparam int KDEN_W = 64;
    localparam int DNUM_W = ROOT_W + 30;

    typedef struct packed {
        t_in_beat        beat;
        logic            active;
        logic            kick;
        logic [2:0]      ovf;
        logic [2:0][41:0] a_mag;
    } t_sb1;

    typedef struct packed {
        t_in_beat         beat;
        logic             active;
        logic [2:0][41:0] a_mag;
        logic [2:0][31:0] vel;
    } t_mid;

    typedef struct packed {
        t_in_beat               beat;
        logic                   active;
        logic [2:0][31:0]       vel;
        logic [2:0]             s_neg;
        logic [2:0][ROOT_W-1:0] s_mag;
    } t_sb2;

    typedef struct packed {
        t_in_beat         beat;
        logic             active;
        logic [2:0][31:0] vel;
        logic [2:0]       s_neg;
        logic [31:0]      mod_new;
        logic             len_zero;
    } t_sb3;

    logic r_spin_enable;
    logic [31:0] r_time_step;
    logic [31:0] r_kick_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_enable <= 1'b1;
            r_time_step   <= '0;
            r_kick_scale  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPIN_ENABLE: r_spin_enable <= i_cfg_data[0];
                CFG_TIME_STEP:   r_time_step   <= i_cfg_data;
                CFG_KICK_SCALE:  r_kick_scale  <= i_cfg_data;
                default:         r_spin_enable <= r_spin_enable;
            endcase
        end
    end

    logic            adv;
    logic [NSTG-1:0] r_vld;

    assign adv        = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    // input register
    t_in_beat r_p0;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p0 <= i_in.data;
        end
    end

    // products
    logic [2:0][31:0] p0_frc, p0_dir, p0_fmag, p0_dmag;
    t_in_beat         r_p1;
    logic             r_p1_active;
    logic [2:0][63:0] r_p1_kp, r_p1_am;
    logic [63:0]      r_p1_den;

    assign p0_frc = {r_p0.force_z, r_p0.force_y, r_p0.force_x};
    assign p0_dir = {r_p0.dir_z, r_p0.dir_y, r_p0.dir_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p0_fmag[k] = p0_frc[k][31] ? 32'(-p0_frc[k]) : p0_frc[k];
            p0_dmag[k] = p0_dir[k][31] ? 32'(-p0_dir[k]) : p0_dir[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1        <= r_p0;
            r_p1_active <= r_spin_enable && (r_p0.spin_inertia != '0);
            r_p1_den    <= 64'(r_p0.spin_inertia) * 64'(r_p0.modulus);
            for (int k = 0; k < 3; k++) begin
                r_p1_kp[k] <= 64'(r_kick_scale) * 64'(p0_fmag[k]);
                r_p1_am[k] <= 64'(r_p0.modulus) * 64'(p0_dmag[k]);
            end
        end
    end

    // kick divider setup
    t_sb1 p1_sb;
    logic [2:0][KDEN_W+KICK_Q_W-1:0] p1_acc;
    t_sb1 r_p2_sb;
    logic [2:0][KDEN_W+KICK_Q_W-1:0] r_p2_acc;
    logic [KDEN_W-1:0] r_p2_den;

    always_comb begin
        p1_sb.beat   = r_p1;
        p1_sb.active = r_p1_active;
        p1_sb.kick   = r_p1_active && (r_p1.modulus != '0);
        for (int k = 0; k < 3; k++) begin
            p1_sb.ovf[k]   = {9'd0, r_p1_kp[k], 24'd0} >= {r_p1_den, 33'd0};
            p1_sb.a_mag[k] = r_p1_am[k][63:22];
            p1_acc[k]      = p1_sb.ovf[k] ? '0 : {9'd0, r_p1_kp[k], 24'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_sb  <= p1_sb;
            r_p2_acc <= p1_acc;
            r_p2_den <= r_p1_den;
        end
    end

    logic [2:0][KICK_Q_W-1:0] kick_quo;
    t_sb1 d1_sb;

    for (genvar k = 0; k < 3; k++) begin : g_kdiv
        isv_udiv #(.DEN_W(KDEN_W), .Q_W(KICK_Q_W)) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_acc (r_p2_acc[k]),
            .i_den (r_p2_den),
            .o_quo (kick_quo[k])
        );
    end

    isv_delay #(.T(t_sb1), .DEPTH(KICK_Q_W)) u_sb1 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   (r_p2_sb),
        .o_q   (d1_sb)
    );

    // velocity update
    logic [2:0][31:0] d1_vel, d1_frc, d1_vnew;
    t_mid r_p3;

    assign d1_vel = {d1_sb.beat.vel_z, d1_sb.beat.vel_y, d1_sb.beat.vel_x};
    assign d1_frc = {d1_sb.beat.force_z, d1_sb.beat.force_y, d1_sb.beat.force_x};

    always_comb begin
        logic [KICK_Q_W-1:0] q;
        logic [33:0]         s;
        for (int k = 0; k < 3; k++) begin
            q = (d1_sb.ovf[k] || kick_quo[k] > {1'b1, 32'd0}) ? {1'b1, 32'd0}
                                                             : kick_quo[k];
            s = d1_frc[k][31] ? {{2{d1_vel[k][31]}}, d1_vel[k]} - {1'b0, q}
                              : {{2{d1_vel[k][31]}}, d1_vel[k]} + {1'b0, q};
            if (!d1_sb.kick) begin
                d1_vnew[k] = d1_vel[k];
            end else if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
                d1_vnew[k] = s[31:0];
            end else begin
                d1_vnew[k] = s[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3.beat   <= d1_sb.beat;
            r_p3.active <= d1_sb.active;
            r_p3.a_mag  <= d1_sb.a_mag;
            r_p3.vel    <= d1_vnew;
        end
    end

    // drift product
    t_mid r_p4;
    logic [2:0][63:0] r_p4_bp;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p4 <= r_p3;
            for (int k = 0; k < 3; k++) begin
                r_p4_bp[k] <= 64'(r_time_step)
                            * 64'(r_p3.vel[k][31] ? 32'(-r_p3.vel[k]) : r_p3.vel[k]);
            end
        end
    end

    // drifted spin components
    logic [2:0][31:0] p4_dir;
    t_sb2 p4_sb, r_p5;

    assign p4_dir = {r_p4.beat.dir_z, r_p4.beat.dir_y, r_p4.beat.dir_x};

    always_comb begin
        logic [50:0] a;
        logic [50:0] b;
        logic [50:0] s;
        p4_sb.beat   = r_p4.beat;
        p4_sb.active = r_p4.active;
        p4_sb.vel    = r_p4.vel;
        for (int k = 0; k < 3; k++) begin
            a = 51'(r_p4.a_mag[k]);
            b = 51'(r_p4_bp[k][63:16]);
            s = (p4_dir[k][31] ? -a : a) + (r_p4.vel[k][31] ? -b : b);
            p4_sb.s_neg[k] = s[50];
            p4_sb.s_mag[k] = s[50] ? ROOT_W'(-s) : s[ROOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p5 <= p4_sb;
        end
    end

    // squares as partial products
    localparam int HALF_W = ROOT_W / 2;
    localparam int SQ_W   = 2 * ROOT_W;
    t_sb2 r_p6;
    logic [2:0][2*HALF_W-1:0] r_p6_hh, r_p6_hl, r_p6_ll;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p6 <= r_p5;
            for (int k = 0; k < 3; k++) begin
                r_p6_hh[k] <= r_p5.s_mag[k][ROOT_W-1:HALF_W] * r_p5.s_mag[k][ROOT_W-1:HALF_W];
                r_p6_hl[k] <= r_p5.s_mag[k][ROOT_W-1:HALF_W] * r_p5.s_mag[k][HALF_W-1:0];
                r_p6_ll[k] <= r_p5.s_mag[k][HALF_W-1:0] * r_p5.s_mag[k][HALF_W-1:0];
            end
        end
    end

    t_sb2 r_p7;
    logic [2:0][SQ_W-1:0] r_p7_sq;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p7 <= r_p6;
            for (int k = 0; k < 3; k++) begin
                r_p7_sq[k] <= (SQ_W'(r_p6_hh[k]) << (2 * HALF_W))
                            + (SQ_W'(r_p6_hl[k]) << (HALF_W + 1))
                            + SQ_W'(r_p6_ll[k]);
            end
        end
    end

    t_sb2 r_p8;
    logic [SQ_W-1:0] r_p8_rad;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p8     <= r_p7;
            r_p8_rad <= r_p7_sq[0] + r_p7_sq[1] + r_p7_sq[2];
        end
    end

    logic [ROOT_W-1:0] len;
    t_sb2 d2_sb;

    isv_usqrt #(.ROOT_W(ROOT_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (r_p8_rad),
        .o_root (len)
    );

    isv_delay #(.T(t_sb2), .DEPTH(ROOT_W)) u_sb2 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   (r_p8),
        .o_q   (d2_sb)
    );

    // direction divider setup
    t_sb3 r_p9_sb;
    logic [2:0][DNUM_W:0] r_p9_acc;
    logic [ROOT_W-1:0] r_p9_den;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p9_sb.beat     <= d2_sb.beat;
            r_p9_sb.active   <= d2_sb.active;
            r_p9_sb.vel      <= d2_sb.vel;
            r_p9_sb.s_neg    <= d2_sb.s_neg;
            r_p9_sb.len_zero <= (len == '0);
            r_p9_sb.mod_new  <= (len[ROOT_W-1:40] != '0) ? 32'hFFFF_FFFF : len[39:8];
            r_p9_den         <= len;
            for (int k = 0; k < 3; k++) begin
                r_p9_acc[k] <= {1'b0, d2_sb.s_mag[k], 30'd0};
            end
        end
    end

    logic [2:0][DIR_Q_W-1:0] dir_quo;
    t_sb3 d3_sb;

    for (genvar k = 0; k < 3; k++) begin : g_ddiv
        isv_udiv #(.DEN_W(ROOT_W), .Q_W(DIR_Q_W)) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_acc (r_p9_acc[k]),
            .i_den (r_p9_den),
            .o_quo (dir_quo[k])
        );
    end

    isv_delay #(.T(t_sb3), .DEPTH(DIR_Q_W)) u_sb3 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   (r_p9_sb),
        .o_q   (d3_sb)
    );

    // result select
    logic [2:0][31:0] d3_dir, res_dir;
    logic [31:0]      res_mod;
    t_out_beat        r_out;

    assign d3_dir = {d3_sb.beat.dir_z, d3_sb.beat.dir_y, d3_sb.beat.dir_x};

    always_comb begin
        logic [DIR_Q_W-1:0] q;
        q       = '0;
        res_dir = d3_dir;
        res_mod = d3_sb.beat.modulus;
        if (d3_sb.active && d3_sb.beat.operation == OP_KICK_DRIFT) begin
            res_mod = d3_sb.mod_new;
            if (!d3_sb.len_zero) begin
                for (int k = 0; k < 3; k++) begin
                    q = (dir_quo[k] > {1'b1, 30'd0}) ? {1'b1, 30'd0} : dir_quo[k];
                    res_dir[k] = d3_sb.s_neg[k] ? 32'(-32'(q)) : 32'(q);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.new_dir_x   <= res_dir[0];
            r_out.new_dir_y   <= res_dir[1];
            r_out.new_dir_z   <= res_dir[2];
            r_out.new_modulus <= res_mod;
            r_out.new_vel_x   <= d3_sb.vel[0];
            r_out.new_vel_y   <= d3_sb.vel[1];
            r_out.new_vel_z   <= d3_sb.vel[2];
        end
    end

    assign o_out.valid = r_vld[NSTG-1];
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_count_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.valid && i_in.ready) && !(o_out.valid && o_out.ready)
        |=> $countones(r_vld) == $past($countones(r_vld)))
        else $error("beat count changed without a handshake");
`endif
endmodule
